FILE: hw/rtl/gcd_pkg.sv
// Shared constants, types and tables for the great-circle distance pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package gcd_pkg;

  localparam int DEF_ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS        = 28;
  localparam int SQRT_STEPS          = 31;

  // Datapath width of the CORDIC x, y and z registers.
  localparam int DP_W = 34;
  typedef logic signed [DP_W-1:0] dp_t;

  localparam logic [31:0] CORDIC_START_X = 32'd652032874;
  localparam logic [63:0] NM_MUL         = 64'd553333248;
  localparam logic [63:0] NM_HALF        = 64'd214748364800;
  localparam logic [31:0] DIV100_MAGIC   = 32'd1374389535;
  localparam int          DIV100_SHIFT   = 37;
  localparam logic [21:0] DIST_MAX       = 22'd2766666;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  function automatic dp_t atan_turn(input int step);
    return dp_t'({2'b00, ATAN_TURNS[step]});
  endfunction

endpackage

FILE: hw/rtl/gcd_cell.sv
// One CORDIC micro-rotation with its output registers.
// Depends on gcd_pkg for the datapath type and the arctangent table.
`timescale 1ns / 1ps
module gcd_cell import gcd_pkg::*; #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  dp_t  x_in,
  input  dp_t  y_in,
  input  dp_t  z_in,
  output dp_t  x_out,
  output dp_t  y_out,
  output dp_t  z_out
);

  dp_t  x_r, y_r, z_r;
  dp_t  dx, dy, ang;
  logic sub_x;

  always_comb begin
    dx  = y_in >>> STEP;
    dy  = x_in >>> STEP;
    ang = atan_turn(STEP);
    // Rotation drives z toward zero; vectoring drives y toward zero.
    if (VECTOR) begin
      sub_x = !(!y_in[DP_W-1] && (y_in != '0));
    end else begin
      sub_x = !z_in[DP_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= sub_x ? x_in - dx : x_in + dx;
      y_r <= sub_x ? y_in + dy : y_in - dy;
      z_r <= sub_x ? z_in - ang : z_in + ang;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

FILE: hw/rtl/gcd_cordic.sv
// A chain of CORDIC cells, one step per cell, one new vector per cycle while en is high.
// Depends on gcd_pkg and gcd_cell.
`timescale 1ns / 1ps
module gcd_cordic import gcd_pkg::*; #(
  parameter bit VECTOR = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  dp_t  x_in,
  input  dp_t  y_in,
  input  dp_t  z_in,
  output dp_t  x_out,
  output dp_t  y_out,
  output dp_t  z_out
);

  dp_t xs [CORDIC_STEPS+1];
  dp_t ys [CORDIC_STEPS+1];
  dp_t zs [CORDIC_STEPS+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    gcd_cell #(.STEP(i), .VECTOR(VECTOR)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (xs[i]),
      .y_in  (ys[i]),
      .z_in  (zs[i]),
      .x_out (xs[i+1]),
      .y_out (ys[i+1]),
      .z_out (zs[i+1])
    );
  end

  assign x_out = xs[CORDIC_STEPS];
  assign y_out = ys[CORDIC_STEPS];
  assign z_out = zs[CORDIC_STEPS];

endmodule

FILE: hw/rtl/gcd_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Carries the clamped cosine alongside. Depends on gcd_pkg.
`timescale 1ns / 1ps
module gcd_sqrt import gcd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [60:0]        n_in,
  input  logic signed [31:0] c_in,
  output logic [30:0]        root_out,
  output logic signed [31:0] c_out
);

  logic [61:0]        rem_r  [SQRT_STEPS];
  logic [30:0]        root_r [SQRT_STEPS];
  logic signed [31:0] c_r    [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    localparam int B = SQRT_STEPS - 1 - k;
    logic [61:0]        rem_prev;
    logic [30:0]        root_prev;
    logic signed [31:0] c_prev;
    logic [61:0]        test;

    if (k == 0) begin : g_first
      assign rem_prev  = {1'b0, n_in};
      assign root_prev = '0;
      assign c_prev    = c_in;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign c_prev    = c_r[k-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
    assign test = ({31'd0, root_prev} << (B + 1)) + (62'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[k] <= c_prev;
        if (rem_prev >= test) begin
          rem_r[k]  <= rem_prev - test;
          root_r[k] <= root_prev | (31'd1 << B);
        end else begin
          rem_r[k]  <= rem_prev;
          root_r[k] <= root_prev;
        end
      end
    end
  end

  assign root_out = root_r[SQRT_STEPS-1];
  assign c_out    = c_r[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/great_circle_distance_nm.sv
// Great-circle distance between two points in nautical miles times 256.
// Input channel: in_valid / in_stall with four angle fields in degrees
// times 2^ANGLE_FRAC_BITS. Result channel: out_valid / out_stall with one
// 22-bit unsigned distance for every request, in request order.
// The block is a single pipeline of 97 register stages: angle to phase (2),
// sine/cosine cell chains (28), cosine products and clamp (3), square of
// the cosine (1), square-root cells (31), arccosine set-up (1), arccosine
// cell chains (28) and scaling to nautical miles (3). One request is taken
// every cycle while the pipeline is not held.
// When out_stall is high while a result is shown, the whole pipeline holds
// and in_stall rises in the same cycle; it falls again as soon as the
// waiting result is taken. Nothing is stored between requests.
// Reset (rst_n low, synchronous) empties the pipeline: no result is valid
// after reset until new requests have travelled through it.
// Depends on gcd_pkg, gcd_cordic, gcd_cell and gcd_sqrt.
`timescale 1ns / 1ps
module great_circle_distance_nm import gcd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_point_a_latitude,
  input  logic signed [24:0] in_point_a_longitude,
  input  logic signed [23:0] in_point_b_latitude,
  input  logic signed [24:0] in_point_b_longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [21:0]        out_distance_nautical_miles
);

  localparam int LAT = 2 + CORDIC_STEPS + 3 + 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 3;
  localparam logic [63:0] DEG_TO_PHASE = (64'd1 << (64 - ANGLE_FRAC_BITS)) / 64'd360;
  localparam logic [23:0] M_LO = DEG_TO_PHASE[23:0];
  localparam logic [23:0] M_HI = DEG_TO_PHASE[47:24];
  localparam int NANG = 4;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Angle to phase: raw * M split into two partial products.
  logic signed [24:0] raw [NANG];
  logic signed [49:0] plo_r [NANG];
  logic signed [49:0] phi_r [NANG];
  logic [31:0]        phase [NANG];

  assign raw[0] = 25'(in_point_a_latitude);
  assign raw[1] = in_point_a_longitude;
  assign raw[2] = 25'(in_point_b_latitude);
  assign raw[3] = in_point_b_longitude;

  for (genvar a = 0; a < NANG; a++) begin : g_phase
    logic [63:0] psum;
    always_ff @(posedge clk) begin
      if (en) begin
        plo_r[a] <= raw[a] * $signed({1'b0, M_LO});
        phi_r[a] <= raw[a] * $signed({1'b0, M_HI});
      end
    end
    assign psum     = 64'(plo_r[a]) + (64'(phi_r[a]) << 24);
    assign phase[a] = psum[63:32];
  end

  // Fold both latitudes and the longitude difference into [-1/4, 1/4) turn; the flip negates sin and cos.
  logic [31:0] rot_ph [3];
  dp_t         rot_z_r [3];
  logic [2:0]  flip_nxt;
  logic [2:0]  flip_pipe_r [CORDIC_STEPS+1];

  assign rot_ph[0] = phase[0];
  assign rot_ph[1] = phase[2];
  assign rot_ph[2] = phase[1] - phase[3];

  for (genvar r = 0; r < 3; r++) begin : g_fold
    logic [31:0] shifted;
    logic [31:0] folded;
    assign shifted     = rot_ph[r] + 32'h4000_0000;
    assign flip_nxt[r] = shifted[31];
    assign folded      = flip_nxt[r] ? (rot_ph[r] ^ 32'h8000_0000) : rot_ph[r];
    always_ff @(posedge clk) begin
      if (en) begin
        rot_z_r[r] <= dp_t'($signed(folded));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flip_pipe_r[0] <= flip_nxt;
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        flip_pipe_r[i] <= flip_pipe_r[i-1];
      end
    end
  end

  dp_t rx [3];
  dp_t ry [3];
  dp_t cs [3];
  dp_t sn [3];

  for (genvar r = 0; r < 3; r++) begin : g_rot
    dp_t rz;
    gcd_cordic #(.VECTOR(1'b0)) u_rot (
      .clk   (clk),
      .en    (en),
      .x_in  (dp_t'({2'b00, CORDIC_START_X})),
      .y_in  ('0),
      .z_in  (rot_z_r[r]),
      .x_out (rx[r]),
      .y_out (ry[r]),
      .z_out (rz)
    );
    assign cs[r] = flip_pipe_r[CORDIC_STEPS][r] ? -rx[r] : rx[r];
    assign sn[r] = flip_pipe_r[CORDIC_STEPS][r] ? -ry[r] : ry[r];
  end

  // Cosine of the central angle, with floor shifts after each product.
  logic signed [2*DP_W-1:0] prod_cc, prod_ss, prod_3;
  dp_t                      t1_r, t2_r, cd_r, t3_r, t2d_r;
  logic signed [DP_W:0]     c_sum;
  logic signed [31:0]       c_r;
  logic signed [63:0]       c_sq;
  logic [60:0]              n_r;
  logic signed [31:0]       cq_r;

  assign prod_cc = cs[0] * cs[1];
  assign prod_ss = sn[0] * sn[1];
  assign prod_3  = t1_r * cd_r;
  assign c_sum   = (DP_W+1)'(t3_r) + (DP_W+1)'(t2d_r);
  assign c_sq    = c_r * c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= $signed(prod_cc[DP_W+29:30]);
      t2_r  <= $signed(prod_ss[DP_W+29:30]);
      cd_r  <= cs[2];
      t3_r  <= $signed(prod_3[DP_W+29:30]);
      t2d_r <= t2_r;
      if (c_sum > (DP_W+1)'(64'sd1 << 30)) begin
        c_r <= 32'sd1 << 30;
      end else if (c_sum < -((DP_W+1)'(64'sd1 << 30))) begin
        c_r <= -(32'sd1 << 30);
      end else begin
        c_r <= 32'(c_sum);
      end
      n_r  <= 61'((64'sd1 << 60) - c_sq);
      cq_r <= c_r;
    end
  end

  logic [30:0]        s_root;
  logic signed [31:0] c_sr;

  gcd_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .n_in     (n_r),
    .c_in     (cq_r),
    .root_out (s_root),
    .c_out    (c_sr)
  );

  // Arccosine: a negative cosine starts a quarter turn around.
  dp_t vx_r, vy_r, vz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_sr[31]) begin
        vx_r <= dp_t'({3'b000, s_root});
        vy_r <= -dp_t'(c_sr);
        vz_r <= dp_t'(64'sd1 << 30);
      end else begin
        vx_r <= dp_t'(c_sr);
        vy_r <= dp_t'({3'b000, s_root});
        vz_r <= '0;
      end
    end
  end

  dp_t ax, ay, psi;

  gcd_cordic #(.VECTOR(1'b1)) u_acos (
    .clk   (clk),
    .en    (en),
    .x_in  (vx_r),
    .y_in  (vy_r),
    .z_in  (vz_r),
    .x_out (ax),
    .y_out (ay),
    .z_out (psi)
  );

  // Scale to nautical miles; division by 100 is a reciprocal multiply.
  logic [31:0] psi_c;
  logic [63:0] p_r;
  logic [63:0] q_r;
  logic [21:0] dist_r;

  always_comb begin
    if (psi[DP_W-1]) begin
      psi_c = '0;
    end else if (psi > dp_t'(64'sd1 << 31)) begin
      psi_c = 32'h8000_0000;
    end else begin
      psi_c = psi[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= {32'd0, psi_c} * NM_MUL + NM_HALF;
      q_r    <= {32'd0, p_r[63:32]} * {32'd0, DIV100_MAGIC};
      dist_r <= q_r[DIV100_SHIFT+21:DIV100_SHIFT];
    end
  end

  assign out_valid                   = vld_r[LAT-1];
  assign out_distance_nautical_miles = dist_r;

  logic unused_ok;
  assign unused_ok = ^{ax, ay, rx[0][0], ry[2][0]};

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_nautical_miles <= DIST_MAX)
    else $error("distance above the largest possible value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cos_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[32] |-> (c_r <= (32'sd1 << 30)) && (c_r >= -(32'sd1 << 30)))
    else $error("clamped cosine out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved while held");

endmodule
